FILE: rtl/core/cbz_pkg.sv
package cbz_pkg;

    localparam int CFG_WIDTH = 6;
    localparam int IDX_WIDTH = 6;
    localparam logic [CFG_WIDTH-1:0] CFG_RESET = 6'd16;

    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic [IDX_WIDTH-1:0] idx;
    } tag_t;

endpackage

FILE: rtl/core/cubic_bezier_sampler.sv
// Cubic Bezier sampler.
// Input channel (s_valid/s_ready): one transaction carries the four control
// points of a segment. Config channel (cfg_valid/cfg_ready, always ready)
// writes the interval count n; write it only while the block is idle.
// Count zero yields one point, the start point; counts above MAX_SAMPLES clamp.
// Result channel (m_valid/m_ready): n+1 transactions per segment, j = 0..n,
// each with the rounded curve point, the sample index and a last flag.
// Throughput: one point per cycle while the receiver is not stalling, set by
// the sample counter that feeds the pipeline; the next segment is taken in
// the cycle the last sample of the current one is issued.
// Pipeline: each point passes five arithmetic stages, then a restoring divider
// by 2*n^3 that resolves one quotient bit per stage.
// Reset clears all valid bits, the sample counter and sets n to 16.
// A stalled receiver freezes the whole pipeline; nothing is lost or repeated.
module cubic_bezier_sampler #(
    parameter int MAX_SAMPLES = 63,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cbz_pkg::CFG_WIDTH-1:0]       cfg_samples_per_segment,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [COORD_WIDTH-1:0]       s_start_x,
    input  logic signed [COORD_WIDTH-1:0]       s_start_y,
    input  logic signed [COORD_WIDTH-1:0]       s_handle_a_x,
    input  logic signed [COORD_WIDTH-1:0]       s_handle_a_y,
    input  logic signed [COORD_WIDTH-1:0]       s_handle_b_x,
    input  logic signed [COORD_WIDTH-1:0]       s_handle_b_y,
    input  logic signed [COORD_WIDTH-1:0]       s_end_x,
    input  logic signed [COORD_WIDTH-1:0]       s_end_y,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [COORD_WIDTH-1:0]       m_point_x,
    output logic signed [COORD_WIDTH-1:0]       m_point_y,
    output logic [cbz_pkg::IDX_WIDTH-1:0]       m_sample_index,
    output logic                                m_last_sample
);

    import cbz_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int NW  = $clog2(MAX_SAMPLES + 1);
    localparam int N2W = 2 * NW;
    localparam int N3W = 3 * NW;
    localparam int PW  = N3W + 1 + CW;
    localparam int SW  = PW + 1;
    localparam int RW  = N3W + CW + 1;
    localparam int AW  = RW + 3;
    localparam int DW  = N3W + 1;
    localparam int LAT = 6 + CW;

    logic [CFG_WIDTH-1:0] cfg_reg;

    logic                   busy_reg;
    logic [NW-1:0]          j_reg;
    logic [NW-1:0]          n_end_reg;
    logic [NW-1:0]          n_calc_reg;
    logic signed [CW-1:0]   seg_reg [8];
    logic [NW-1:0]          n_end_next;
    logic signed [CW-1:0]   s_coord [8];

    logic ce;
    logic gen_fire;
    logic gen_done;

    tag_t tag_reg [1:LAT];

    logic [NW-1:0]          k1_reg, j1_reg, n1_reg;
    logic signed [CW-1:0]   p1_reg [8];
    logic [N2W-1:0]         ksq_reg, jsq_reg, nsq_reg;
    logic [NW-1:0]          k2_reg, j2_reg, n2_reg;
    logic signed [CW-1:0]   p2_reg [8];
    logic [N3W-1:0]         kkj, kjj;
    logic [N3W-1:0]         w_reg [4];
    logic [N3W-1:0]         n3_reg;
    logic signed [CW-1:0]   p3_reg [8];
    logic signed [PW-1:0]   pr_reg [8];
    logic [N3W-1:0]         n3_4_reg;
    logic signed [SW-1:0]   s01_reg [2];
    logic signed [SW-1:0]   s23_reg [2];
    logic [RW-1:0]          off_reg;
    logic [DW-1:0]          dsr_reg;

    logic signed [AW-1:0]   a_sum  [2];
    logic signed [AW-1:0]   a_full [2];
    logic [CW-1:0]          quo    [2];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cfg_reg <= cfg_samples_per_segment;
        end
    end

    assign ce       = !m_valid || m_ready;
    assign gen_fire = busy_reg && ce;
    assign gen_done = gen_fire && (j_reg == n_end_reg);
    assign s_ready  = !busy_reg || gen_done;

    always_comb begin
        if (int'(cfg_reg) > MAX_SAMPLES) begin
            n_end_next = NW'(MAX_SAMPLES);
        end else begin
            n_end_next = NW'(cfg_reg);
        end
        s_coord[0] = s_start_x;
        s_coord[1] = s_start_y;
        s_coord[2] = s_handle_a_x;
        s_coord[3] = s_handle_a_y;
        s_coord[4] = s_handle_b_x;
        s_coord[5] = s_handle_b_y;
        s_coord[6] = s_end_x;
        s_coord[7] = s_end_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            j_reg    <= '0;
        end else if (s_valid && s_ready) begin
            busy_reg <= 1'b1;
            j_reg    <= '0;
        end else if (gen_done) begin
            busy_reg <= 1'b0;
        end else if (gen_fire) begin
            j_reg <= j_reg + 1'b1;
        end
    end

    // hold the segment while its samples issue; zero intervals run as n = 1, j = 0
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            n_end_reg  <= n_end_next;
            n_calc_reg <= (n_end_next == '0) ? NW'(1) : n_end_next;
            for (int i = 0; i < 8; i++) begin
                seg_reg[i] <= s_coord[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= LAT; i++) begin
                tag_reg[i] <= '0;
            end
        end else if (ce) begin
            tag_reg[1].valid <= busy_reg;
            tag_reg[1].last  <= (j_reg == n_end_reg);
            tag_reg[1].idx   <= IDX_WIDTH'(j_reg);
            for (int i = 2; i <= LAT; i++) begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    always_comb begin
        kkj = N3W'(ksq_reg) * N3W'(j2_reg);
        kjj = N3W'(jsq_reg) * N3W'(k2_reg);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            k1_reg <= n_calc_reg - j_reg;
            j1_reg <= j_reg;
            n1_reg <= n_calc_reg;
            for (int i = 0; i < 8; i++) begin
                p1_reg[i] <= seg_reg[i];
            end

            ksq_reg <= N2W'(k1_reg) * N2W'(k1_reg);
            jsq_reg <= N2W'(j1_reg) * N2W'(j1_reg);
            nsq_reg <= N2W'(n1_reg) * N2W'(n1_reg);
            k2_reg  <= k1_reg;
            j2_reg  <= j1_reg;
            n2_reg  <= n1_reg;
            for (int i = 0; i < 8; i++) begin
                p2_reg[i] <= p1_reg[i];
            end

            w_reg[0] <= N3W'(ksq_reg) * N3W'(k2_reg);
            w_reg[1] <= kkj + (kkj << 1);
            w_reg[2] <= kjj + (kjj << 1);
            w_reg[3] <= N3W'(jsq_reg) * N3W'(j2_reg);
            n3_reg   <= N3W'(nsq_reg) * N3W'(n2_reg);
            for (int i = 0; i < 8; i++) begin
                p3_reg[i] <= p2_reg[i];
            end

            for (int i = 0; i < 8; i++) begin
                pr_reg[i] <= $signed({1'b0, w_reg[i/2]}) * p3_reg[i];
            end
            n3_4_reg <= n3_reg;

            for (int c = 0; c < 2; c++) begin
                s01_reg[c] <= SW'(pr_reg[c]) + SW'(pr_reg[2+c]);
                s23_reg[c] <= SW'(pr_reg[4+c]) + SW'(pr_reg[6+c]);
            end
            off_reg <= RW'({n3_4_reg, CW'(0)}) + RW'(n3_4_reg);
            dsr_reg <= {n3_4_reg, 1'b0};
        end
    end

    // bias the rounded numerator by 2^(CW-1) divisors so the dividend stays positive
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            a_sum[c]  = AW'(s01_reg[c]) + AW'(s23_reg[c]);
            a_full[c] = (a_sum[c] <<< 1) + $signed(AW'(off_reg));
        end
    end

    cbz_divider #(
        .QW (CW),
        .DW (DW),
        .RW (RW)
    ) u_div_x (
        .aclk     (aclk),
        .ce       (ce),
        .dividend (a_full[0][RW-1:0]),
        .divisor  (dsr_reg),
        .quotient (quo[0])
    );

    cbz_divider #(
        .QW (CW),
        .DW (DW),
        .RW (RW)
    ) u_div_y (
        .aclk     (aclk),
        .ce       (ce),
        .dividend (a_full[1][RW-1:0]),
        .divisor  (dsr_reg),
        .quotient (quo[1])
    );

    assign m_valid        = tag_reg[LAT].valid;
    assign m_last_sample  = tag_reg[LAT].last;
    assign m_sample_index = tag_reg[LAT].idx;
    assign m_point_x      = {~quo[0][CW-1], quo[0][CW-2:0]};
    assign m_point_y      = {~quo[1][CW-1], quo[1][CW-2:0]};

`ifndef NO_ASSERTIONS
    a_calc_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> n_calc_reg != '0)
        else $error("interval count zero while a segment is active");

    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        gen_fire && !gen_done |=> j_reg == NW'($past(j_reg) + 1'b1))
        else $error("sample counter skipped or repeated");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> $stable(tag_reg[LAT]) && $stable(quo[0]) && $stable(quo[1]))
        else $error("output stage moved during a stall");

    a_last_end: assert property (@(posedge aclk) disable iff (!aresetn)
        tag_reg[1].valid && tag_reg[1].last |-> $past(!busy_reg || gen_done || !ce))
        else $error("last flag issued without closing the segment");
`endif

endmodule

FILE: rtl/core/cbz_divider.sv
module cbz_divider #(
    parameter int QW = 16,
    parameter int DW = 19,
    parameter int RW = 35
) (
    input  logic          aclk,
    input  logic          ce,
    input  logic [RW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [QW-1:0] quotient
);

    logic [RW-1:0] rem_reg [QW];
    logic [DW-1:0] dsr_reg [QW];
    logic [QW-1:0] quo_reg [QW+1];

    logic [RW-1:0] shifted   [QW];
    logic [RW:0]   diff      [QW];
    logic [QW-1:0] quo_next  [QW];
    logic [RW-1:0] rem_next  [QW];

    always_comb begin
        for (int t = 0; t < QW; t++) begin
            shifted[t] = RW'(dsr_reg[t]) << (QW - 1 - t);
            diff[t]    = {1'b0, rem_reg[t]} - {1'b0, shifted[t]};
            if (!diff[t][RW]) begin
                quo_next[t] = quo_reg[t] | (QW'(1) << (QW - 1 - t));
                rem_next[t] = diff[t][RW-1:0];
            end else begin
                quo_next[t] = quo_reg[t];
                rem_next[t] = rem_reg[t];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0] <= dividend;
            dsr_reg[0] <= divisor;
            quo_reg[0] <= '0;
            for (int t = 0; t < QW - 1; t++) begin
                rem_reg[t+1] <= rem_next[t];
                dsr_reg[t+1] <= dsr_reg[t];
            end
            for (int t = 0; t < QW; t++) begin
                quo_reg[t+1] <= quo_next[t];
            end
        end
    end

    assign quotient = quo_reg[QW];

endmodule

FILE: tb/tb_cubic_bezier_sampler.sv
module tb_cubic_bezier_sampler;

    import cbz_pkg::*;

    localparam int COORD_W     = 16;
    localparam int MAX_SAMPLES = 63;
    localparam int STALL_LIMIT = 4000;
    localparam int REPORT_MAX  = 10;
    localparam int GROUP_ITEMS = 33;

    localparam logic signed [COORD_W-1:0] CMIN = 16'sh8000;
    localparam logic signed [COORD_W-1:0] CMAX = 16'sh7fff;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx, sy, ax, ay, bx, by, ex, ey;
    } segment_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x, y;
        logic [IDX_WIDTH-1:0]      idx;
        logic                      last;
    } curve_point_t;

    // typed = 1: every point of the segment is (tx, ty)
    typedef struct packed {
        logic [CFG_WIDTH-1:0]      count;
        segment_t                  seg;
        logic                      typed;
        logic signed [COORD_W-1:0] tx, ty;
    } directed_row_t;

    localparam int NUM_DIRECTED = 21;
    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{6'd16, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
          1'b1, 16'sd0, 16'sd0},
        '{6'd16, '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN}, 1'b1, CMAX, CMIN},
        '{6'd16, '{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX}, 1'b1, CMIN, CMAX},
        '{6'd16, '{CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN}, 1'b0, 16'sd0, 16'sd0},
        '{6'd16, '{CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN}, 1'b0, 16'sd0, 16'sd0},
        '{6'd16, '{16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
          1'b0, 16'sd0, 16'sd0},
        '{6'd2, '{16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
          1'b0, 16'sd0, 16'sd0},
        '{6'd2, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, -16'sd1},
          1'b0, 16'sd0, 16'sd0},
        '{6'd1, '{CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN}, 1'b0, 16'sd0, 16'sd0},
        '{6'd1, '{16'sd12345, -16'sd12345, 16'sd12345, -16'sd12345,
                  16'sd12345, -16'sd12345, 16'sd12345, -16'sd12345},
          1'b1, 16'sd12345, -16'sd12345},
        '{6'd0, '{CMAX, CMIN, 16'sd100, -16'sd7, CMIN, CMAX, 16'sd3, 16'sd9},
          1'b1, CMAX, CMIN},
        '{6'd0, '{CMIN, CMAX, CMAX, CMIN, 16'sd0, 16'sd1, -16'sd2, 16'sd5},
          1'b1, CMIN, CMAX},
        '{6'd0, '{16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555,
                  16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555},
          1'b1, 16'sh5555, 16'shaaaa},
        '{6'd63, '{CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN}, 1'b0, 16'sd0, 16'sd0},
        '{6'd63, '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN}, 1'b1, CMAX, CMIN},
        '{6'd63, '{16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd1},
          1'b0, 16'sd0, 16'sd0},
        '{6'd32, '{16'sh0f0f, -16'sd300, 16'sh70f0, 16'sd4000, -16'sd20000, 16'sd77,
                   16'sd555, -16'sd31000}, 1'b0, 16'sd0, 16'sd0},
        '{6'd21, '{16'sh1234, 16'sh4321, -16'sd9999, 16'sd8888, 16'sd7, -16'sd7,
                   CMAX, CMIN}, 1'b0, 16'sd0, 16'sd0},
        '{6'd42, '{CMIN, 16'sd0, 16'sd0, CMAX, CMAX, 16'sd0, 16'sd0, CMIN},
          1'b0, 16'sd0, 16'sd0},
        '{6'd3, '{16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd2, -16'sd2},
          1'b0, 16'sd0, 16'sd0},
        '{6'd16, '{16'shaaaa, 16'sh5555, 16'sh5555, 16'shaaaa,
                   16'shaaaa, 16'sh5555, 16'sh5555, 16'shaaaa}, 1'b0, 16'sd0, 16'sd0}
    };

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_WIDTH-1:0]      cfg_samples_per_segment = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_start_x = '0;
    logic signed [COORD_W-1:0] s_start_y = '0;
    logic signed [COORD_W-1:0] s_handle_a_x = '0;
    logic signed [COORD_W-1:0] s_handle_a_y = '0;
    logic signed [COORD_W-1:0] s_handle_b_x = '0;
    logic signed [COORD_W-1:0] s_handle_b_y = '0;
    logic signed [COORD_W-1:0] s_end_x = '0;
    logic signed [COORD_W-1:0] s_end_y = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [COORD_W-1:0] m_point_x;
    logic signed [COORD_W-1:0] m_point_y;
    logic [IDX_WIDTH-1:0]      m_sample_index;
    logic                      m_last_sample;

    curve_point_t         expected_points [$];
    logic [CFG_WIDTH-1:0] interval_count = CFG_RESET;
    int                   send_gap_pct = 0;
    int                   recv_stall_pct = 0;
    int                   failures = 0;
    int                   points_seen = 0;
    int                   segments_sent = 0;
    int                   settings_used = 0;
    int                   idle_cycles = 0;

    cubic_bezier_sampler #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .COORD_WIDTH(COORD_W)
    ) dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_samples_per_segment(cfg_samples_per_segment),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_start_x              (s_start_x),
        .s_start_y              (s_start_y),
        .s_handle_a_x           (s_handle_a_x),
        .s_handle_a_y           (s_handle_a_y),
        .s_handle_b_x           (s_handle_b_x),
        .s_handle_b_y           (s_handle_b_y),
        .s_end_x                (s_end_x),
        .s_end_y                (s_end_y),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_point_x              (m_point_x),
        .m_point_y              (m_point_y),
        .m_sample_index         (m_sample_index),
        .m_last_sample          (m_last_sample)
    );

    always #1 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= (int'($urandom_range(0, 99)) >= recv_stall_pct);
    end

    // rounded weighted sum over n^3, ties toward plus infinity
    function automatic logic signed [COORD_W-1:0] blend_coord(
        input longint p0, input longint p1, input longint p2, input longint p3,
        input longint n, input longint j);
        longint k, n3, numer, denom, q;
        k = n - j;
        n3 = n * n * n;
        numer = 2 * (k * k * k * p0 + 3 * k * k * j * p1 + 3 * k * j * j * p2
                     + j * j * j * p3) + n3;
        denom = 2 * n3;
        q = numer / denom;
        if ((numer % denom) != 0 && numer < 0) begin
            q = q - 1;
        end
        return q[COORD_W-1:0];
    endfunction

    // append at the tail of the expected queue
    function automatic void queue_point(input curve_point_t pt);
        expected_points.insert(expected_points.size(), pt);
    endfunction

    function automatic void predict_points(input segment_t seg);
        longint       n;
        curve_point_t pt;
        n = longint'(interval_count);
        if (n > MAX_SAMPLES) begin
            n = MAX_SAMPLES;
        end
        if (n == 0) begin
            pt = '{seg.sx, seg.sy, '0, 1'b1};
            queue_point(pt);
        end else begin
            for (longint j = 0; j <= n; j++) begin
                pt.x = blend_coord($signed(seg.sx), $signed(seg.ax), $signed(seg.bx),
                                   $signed(seg.ex), n, j);
                pt.y = blend_coord($signed(seg.sy), $signed(seg.ay), $signed(seg.by),
                                   $signed(seg.ey), n, j);
                pt.idx = j[IDX_WIDTH-1:0];
                pt.last = (j == n);
                queue_point(pt);
            end
        end
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        int          v;
        logic [31:0] bits;
        case ($urandom_range(0, 9))
            0: begin
                return CMIN;
            end
            1: begin
                return CMAX;
            end
            2: begin
                v = int'($urandom_range(0, 6)) - 3;
                return v[COORD_W-1:0];
            end
            default: begin
                bits = $urandom();
                return bits[COORD_W-1:0];
            end
        endcase
    endfunction

    function automatic segment_t random_segment();
        segment_t                  seg;
        logic signed [COORD_W-1:0] cx, cy;
        case ($urandom_range(0, 7))
            0: begin
                cx = rand_coord();
                cy = rand_coord();
                seg = '{cx, cy, cx, cy, cx, cy, cx, cy};
            end
            1: begin
                seg.sx = $urandom_range(0, 1) ? CMAX : CMIN;
                seg.sy = $urandom_range(0, 1) ? CMAX : CMIN;
                seg.ax = $urandom_range(0, 1) ? CMAX : CMIN;
                seg.ay = $urandom_range(0, 1) ? CMAX : CMIN;
                seg.bx = $urandom_range(0, 1) ? CMAX : CMIN;
                seg.by = $urandom_range(0, 1) ? CMAX : CMIN;
                seg.ex = $urandom_range(0, 1) ? CMAX : CMIN;
                seg.ey = $urandom_range(0, 1) ? CMAX : CMIN;
            end
            default: begin
                seg = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord(), rand_coord()};
            end
        endcase
        return seg;
    endfunction

    // call at a falling edge; returns at the falling edge after the transaction
    task automatic send_segment(input segment_t seg);
        while (int'($urandom_range(0, 99)) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_start_x    <= seg.sx;
        s_start_y    <= seg.sy;
        s_handle_a_x <= seg.ax;
        s_handle_a_y <= seg.ay;
        s_handle_b_x <= seg.bx;
        s_handle_b_y <= seg.by;
        s_end_x      <= seg.ex;
        s_end_y      <= seg.ey;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        segments_sent++;
        @(negedge aclk);
    endtask

    // hold off until every expected point is out, leaving the block idle
    task automatic drain_points();
        s_valid <= 1'b0;
        while (expected_points.size() != 0) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic write_count(input logic [CFG_WIDTH-1:0] n);
        cfg_valid               <= 1'b1;
        cfg_samples_per_segment <= n;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        interval_count = n;
        settings_used++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        curve_point_t want;
        if (aresetn && m_valid && m_ready) begin
            points_seen++;
            if (expected_points.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX) begin
                    $display("unexpected point: x=%0d y=%0d j=%0d last=%0b",
                             m_point_x, m_point_y, m_sample_index, m_last_sample);
                end
            end else begin
                want = expected_points.pop_front();
                if (m_point_x !== want.x || m_point_y !== want.y ||
                    m_sample_index !== want.idx || m_last_sample !== want.last) begin
                    failures++;
                    if (failures <= REPORT_MAX) begin
                        $display("point mismatch: expected x=%0d y=%0d j=%0d last=%0b, %s",
                                 want.x, want.y, want.idx, want.last, "got");
                        $display("    got x=%0d y=%0d j=%0d last=%0b",
                                 m_point_x, m_point_y, m_sample_index, m_last_sample);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("cubic_bezier_sampler verification failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        directed_row_t        row;
        segment_t             seg;
        logic [CFG_WIDTH-1:0] n;
        curve_point_t         pt;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_gap_pct   = 38;
        recv_stall_pct = 47;
        for (int r = 0; r < NUM_DIRECTED; r++) begin
            row = DIRECTED_ROWS[r];
            if (row.count != interval_count) begin
                drain_points();
                write_count(row.count);
            end
            send_segment(row.seg);
            if (row.typed) begin
                for (int j = 0; j <= int'(row.count); j++) begin
                    pt = '{row.tx, row.ty, IDX_WIDTH'(j), (j == int'(row.count))};
                    queue_point(pt);
                end
            end else begin
                predict_points(row.seg);
            end
        end

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_gap_pct   = 38;
                    recv_stall_pct = 47;
                end
                1: begin
                    send_gap_pct   = 47;
                    recv_stall_pct = 38;
                end
                default: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int grp = 0; grp < 4; grp++) begin
                if (grp == 0) begin
                    n = (mode == 0) ? 6'd0 : ((mode == 1) ? 6'd63 : 6'd1);
                end else if ($urandom_range(0, 3) == 0) begin
                    n = CFG_WIDTH'($urandom_range(0, 63));
                end else begin
                    n = CFG_WIDTH'($urandom_range(1, 20));
                end
                drain_points();
                write_count(n);
                repeat (GROUP_ITEMS) begin
                    seg = random_segment();
                    send_segment(seg);
                    predict_points(seg);
                end
            end
        end

        drain_points();
        repeat (2 * (COORD_W + 7)) @(posedge aclk);
        if (expected_points.size() != 0) begin
            failures += expected_points.size();
            $display("%0d expected points never arrived", expected_points.size());
        end

        $display("Sampled %0d segments into %0d checked points over %0d interval counts,",
                 segments_sent, points_seen, settings_used);
        $display("including zero and the maximum, with and without back-pressure.");
        if (failures == 0) begin
            $display("cubic_bezier_sampler verification clean");
        end else begin
            $display("%0d failures", failures);
            $display("cubic_bezier_sampler verification failed");
        end
        $finish;
    end

endmodule
